>>> design/cir_pkg.sv
// Package for the contact impulse resolver.
// Holds the item types of both channels and the fixed-point constants.
// No dependencies.
`default_nettype none

package cir_pkg;

	// One contact as it enters the block.
	typedef struct packed {
		logic signed [31:0] vel_a_x;
		logic signed [31:0] vel_a_y;
		logic signed [31:0] vel_a_z;
		logic signed [31:0] vel_b_x;
		logic signed [31:0] vel_b_y;
		logic signed [31:0] vel_b_z;
		logic signed [31:0] normal_x;
		logic signed [31:0] normal_y;
		logic signed [31:0] normal_z;
		logic [30:0]        mass_a;
		logic [30:0]        mass_b;
		logic [31:0]        restitutions;
	} contact_t;

	// One resolved contact.
	typedef struct packed {
		logic signed [31:0] new_vel_a_x;
		logic signed [31:0] new_vel_a_y;
		logic signed [31:0] new_vel_a_z;
		logic signed [31:0] new_vel_b_x;
		logic signed [31:0] new_vel_b_y;
		logic signed [31:0] new_vel_b_z;
		logic               degenerate_normal;
	} result_t;

	// Item data carried along the pipeline.
	typedef struct packed {
		contact_t item;
		logic     deg;
	} carry_t;

	// Unit of the Q2.30 normal and of the mass weights.
	localparam logic [30:0] ONE_Q30  = 31'h4000_0000;
	localparam logic [30:0] HALF_Q30 = 31'h2000_0000;
	// One in the Q.15 restitution format.
	localparam logic [16:0] ONE_Q15  = 17'h0_8000;

endpackage

`default_nettype wire

>>> design/contact_impulse_resolver.sv
// Contact impulse resolver, top level.
// Uses cir_pkg, cir_delay, cir_isqrt, cir_div and cir_rnd_mul.
//
//   channel   signals                                 direction
//   contact   contact_valid, contact_ready, contact   in, one contact_t item
//   result    result_valid, result_ready, result      out, one result_t item
//
// One item enters per cycle while contact_ready is high.
// The pipeline length is set by the 32-stage square root and the 31-stage dividers.
// A skid register behind the last stage takes one result when result_ready
// is low; contact_ready is low while it is full and the pipeline holds.
// Reset clears the valid bits, the skid valid bit among them; data needs no reset.
`default_nettype none

module contact_impulse_resolver (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              contact_valid,
	output logic                   contact_ready,
	input  wire cir_pkg::contact_t contact,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output cir_pkg::result_t       result
);

	import cir_pkg::*;

	localparam int LAT    = 79;
	localparam int SQ_LAT = 32;
	localparam int DV_LAT = 31;

	typedef struct packed {
		carry_t          c;
		logic [2:0][31:0] cmag;
		logic [2:0]      cneg;
	} front_t;

	typedef struct packed {
		carry_t     c;
		logic [2:0] cneg;
		logic       mzero;
	} mid_t;

	typedef struct packed {
		carry_t           c;
		logic [2:0][31:0] u;
	} back_t;

	logic           en;
	logic [LAT-1:0] vld_q;
	logic           skid_vld_q;
	result_t        skid_q;
	result_t        res_s79;

	// Pipeline advances while the skid register is empty.
	assign en            = ~skid_vld_q;
	assign contact_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], contact_valid};
		end
	end

	// Stage 1: normal magnitudes, largest magnitude, zero-normal flag.
	logic signed [31:0] nrm [3];
	logic [2:0][31:0]   nmag_c;
	logic [31:0]        m01;
	logic [31:0]        mx_c;
	carry_t             carry_s1;
	logic [2:0][31:0]   nmag_s1;
	logic [2:0]         nneg_s1;
	logic [31:0]        mx_s1;

	assign nrm[0] = contact.normal_x;
	assign nrm[1] = contact.normal_y;
	assign nrm[2] = contact.normal_z;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			nmag_c[i] = nrm[i][31] ? (~nrm[i] + 32'd1) : nrm[i];
		end
	end

	assign m01  = (nmag_c[0] > nmag_c[1]) ? nmag_c[0] : nmag_c[1];
	assign mx_c = (m01 > nmag_c[2]) ? m01 : nmag_c[2];

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s1.item <= contact;
			carry_s1.deg  <= (mx_c == 32'd0);
			nmag_s1       <= nmag_c;
			nneg_s1       <= {nrm[2][31], nrm[1][31], nrm[0][31]};
			mx_s1         <= mx_c;
		end
	end

	// Stage 2: shift that brings the largest magnitude to bit 30 or 31.
	logic [4:0]       msb_c;
	logic [4:0]       k_c;
	carry_t           carry_s2;
	logic [2:0][31:0] nmag_s2;
	logic [2:0]       nneg_s2;
	logic [4:0]       k_s2;

	always_comb begin
		msb_c = '0;
		for (int i = 0; i < 31; i++) begin
			if (mx_s1[i]) begin
				msb_c = 5'(i);
			end
		end
		if (mx_s1[31] || mx_s1 == 32'd0) begin
			k_c = 5'd0;
		end else begin
			k_c = 5'd30 - msb_c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			carry_s2 <= carry_s1;
			nmag_s2  <= nmag_s1;
			nneg_s2  <= nneg_s1;
			k_s2     <= k_c;
		end
	end

	// Stage 3: scaled normal.
	front_t fr_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s3.c    <= carry_s2;
			fr_s3.cneg <= nneg_s2;
			for (int i = 0; i < 3; i++) begin
				fr_s3.cmag[i] <= nmag_s2[i] << k_s2;
			end
		end
	end

	// Stage 4: squares of the scaled components.
	front_t      fr_s4;
	logic [63:0] sq_s4 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s4 <= fr_s3;
			for (int i = 0; i < 3; i++) begin
				sq_s4[i] <= 64'(fr_s3.cmag[i]) * 64'(fr_s3.cmag[i]);
			end
		end
	end

	// Stage 5: squared length.
	front_t      fr_s5;
	logic [63:0] l2_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			fr_s5 <= fr_s4;
			l2_s5 <= sq_s4[0] + sq_s4[1] + sq_s4[2];
		end
	end

	// Length of the scaled normal, with the item data alongside.
	logic [31:0] len;
	front_t      fr_d;

	cir_isqrt #(.XW(64)) u_isqrt (
		.clk (clk),
		.en  (en),
		.x   (l2_s5),
		.root(len)
	);

	cir_delay #(.W($bits(front_t)), .DEPTH(SQ_LAT)) u_dly_front (
		.clk (clk),
		.en  (en),
		.din (fr_s5),
		.dout(fr_d)
	);

	// Dividers for the unit normal and for the mass weight of body B.
	logic [61:0]      unum [3];
	logic [30:0]      uquo [3];
	logic [31:0]      msum;
	logic [31:0]      mden;
	logic [61:0]      mnum;
	logic [30:0]      mquo;
	mid_t             mid_in;
	mid_t             mid_d;

	for (genvar i = 0; i < 3; i++) begin : g_udiv
		assign unum[i] = {fr_d.cmag[i], 30'h0} + 62'(len[31:1]);

		cir_div #(.NW(62), .DW(32), .QW(31)) u_div (
			.clk(clk),
			.en (en),
			.num(unum[i]),
			.den(len),
			.quo(uquo[i])
		);
	end

	assign msum = 32'(fr_d.c.item.mass_a) + 32'(fr_d.c.item.mass_b);
	assign mden = (msum == 32'd0) ? 32'd1 : msum;
	assign mnum = {1'b0, fr_d.c.item.mass_b, 30'h0} + 62'(msum[31:1]);

	cir_div #(.NW(62), .DW(32), .QW(31)) u_mdiv (
		.clk(clk),
		.en (en),
		.num(mnum),
		.den(mden),
		.quo(mquo)
	);

	assign mid_in.c     = fr_d.c;
	assign mid_in.cneg  = fr_d.cneg;
	assign mid_in.mzero = (msum == 32'd0);

	cir_delay #(.W($bits(mid_t)), .DEPTH(DV_LAT)) u_dly_mid (
		.clk (clk),
		.en  (en),
		.din (mid_in),
		.dout(mid_d)
	);

	// Stage 69: signed unit normal, mass weights, one plus restitution.
	back_t       bk_s69;
	logic [30:0] kb_c;
	logic [30:0] kb_s69;
	logic [30:0] ka_s69;
	logic [16:0] ope_s69;
	logic [15:0] ea;
	logic [15:0] eb;

	assign kb_c = mid_d.mzero ? HALF_Q30 : mquo;
	assign ea   = mid_d.c.item.restitutions[15:0];
	assign eb   = mid_d.c.item.restitutions[31:16];

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s69.c <= mid_d.c;
			for (int i = 0; i < 3; i++) begin
				bk_s69.u[i] <= mid_d.cneg[i] ? -{1'b0, uquo[i]} : {1'b0, uquo[i]};
			end
			kb_s69  <= kb_c;
			ka_s69  <= ONE_Q30 - kb_c;
			ope_s69 <= ONE_Q15 + 17'((ea < eb) ? ea : eb);
		end
	end

	// Stage 70: velocity components times the unit normal.
	logic signed [31:0] va [3];
	logic signed [31:0] vb [3];
	back_t              bk_s70;
	logic signed [63:0] pa_s70 [3];
	logic signed [63:0] pb_s70 [3];
	logic [30:0]        kb_s70;
	logic [30:0]        ka_s70;
	logic [16:0]        ope_s70;

	assign va[0] = bk_s69.c.item.vel_a_x;
	assign va[1] = bk_s69.c.item.vel_a_y;
	assign va[2] = bk_s69.c.item.vel_a_z;
	assign vb[0] = bk_s69.c.item.vel_b_x;
	assign vb[1] = bk_s69.c.item.vel_b_y;
	assign vb[2] = bk_s69.c.item.vel_b_z;

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s70  <= bk_s69;
			kb_s70  <= kb_s69;
			ka_s70  <= ka_s69;
			ope_s70 <= ope_s69;
			for (int i = 0; i < 3; i++) begin
				pa_s70[i] <= 64'(va[i]) * 64'($signed(bk_s69.u[i]));
				pb_s70[i] <= 64'(vb[i]) * 64'($signed(bk_s69.u[i]));
			end
		end
	end

	// Stage 71: dot products.
	back_t              bk_s71;
	logic signed [63:0] dota_s71;
	logic signed [63:0] dotb_s71;
	logic [30:0]        kb_s71;
	logic [30:0]        ka_s71;
	logic [16:0]        ope_s71;

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s71   <= bk_s70;
			kb_s71   <= kb_s70;
			ka_s71   <= ka_s70;
			ope_s71  <= ope_s70;
			dota_s71 <= pa_s70[0] + pa_s70[1] + pa_s70[2];
			dotb_s71 <= pb_s70[0] + pb_s70[1] + pb_s70[2];
		end
	end

	// Stage 72: normal speeds, rounded to the velocity format.
	logic [63:0]        dmag_a;
	logic [63:0]        dmag_b;
	logic [33:0]        ra;
	logic [33:0]        rb;
	back_t              bk_s72;
	logic signed [34:0] sa_s72;
	logic signed [34:0] sb_s72;
	logic [30:0]        kb_s72;
	logic [30:0]        ka_s72;
	logic [16:0]        ope_s72;

	assign dmag_a = dota_s71[63] ? 64'(-dota_s71) : 64'(dota_s71);
	assign dmag_b = dotb_s71[63] ? 64'(-dotb_s71) : 64'(dotb_s71);
	assign ra     = 34'((dmag_a + 64'h2000_0000) >> 30);
	assign rb     = 34'((dmag_b + 64'h2000_0000) >> 30);

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s72  <= bk_s71;
			kb_s72  <= kb_s71;
			ka_s72  <= ka_s71;
			ope_s72 <= ope_s71;
			sa_s72  <= dota_s71[63] ? -$signed({1'b0, ra}) : $signed({1'b0, ra});
			sb_s72  <= dotb_s71[63] ? -$signed({1'b0, rb}) : $signed({1'b0, rb});
		end
	end

	// Stage 73: closing speed along the normal.
	logic signed [35:0] dd;
	back_t              bk_s73;
	logic [34:0]        dmag_s73;
	logic               dneg_s73;
	logic [30:0]        kb_s73;
	logic [30:0]        ka_s73;
	logic [16:0]        ope_s73;

	assign dd = 36'(sb_s72) - 36'(sa_s72);

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s73   <= bk_s72;
			kb_s73   <= kb_s72;
			ka_s73   <= ka_s72;
			ope_s73  <= ope_s72;
			dmag_s73 <= dd[35] ? 35'(-dd) : 35'(dd);
			dneg_s73 <= dd[35];
		end
	end

	// Stage 74: closing speed times one plus restitution.
	back_t       bk_s74;
	logic [50:0] tmag_s74;
	logic        tneg_s74;
	logic [30:0] kb_s74;
	logic [30:0] ka_s74;

	always_ff @(posedge clk) begin
		if (en) begin
			bk_s74   <= bk_s73;
			kb_s74   <= kb_s73;
			ka_s74   <= ka_s73;
			tmag_s74 <= 51'(52'(dmag_s73) * 52'(ope_s73));
			tneg_s74 <= dneg_s73;
		end
	end

	// Normal velocity changes of both bodies.
	logic signed [36:0] da;
	logic signed [36:0] db;
	back_t              bk_d76;
	back_t              bk_d78;

	cir_rnd_mul #(.AMW(51), .BMW(31), .SH(45), .RW(37)) u_mul_da (
		.clk  (clk),
		.en   (en),
		.a_mag(tmag_s74),
		.b_mag(kb_s74),
		.neg  (tneg_s74),
		.res  (da)
	);

	cir_rnd_mul #(.AMW(51), .BMW(31), .SH(45), .RW(37)) u_mul_db (
		.clk  (clk),
		.en   (en),
		.a_mag(tmag_s74),
		.b_mag(ka_s74),
		.neg  (~tneg_s74),
		.res  (db)
	);

	cir_delay #(.W($bits(back_t)), .DEPTH(2)) u_dly_back0 (
		.clk (clk),
		.en  (en),
		.din (bk_s74),
		.dout(bk_d76)
	);

	cir_delay #(.W($bits(back_t)), .DEPTH(2)) u_dly_back1 (
		.clk (clk),
		.en  (en),
		.din (bk_d76),
		.dout(bk_d78)
	);

	// Velocity changes projected back onto the axes.
	logic [35:0]        damag;
	logic [35:0]        dbmag;
	logic signed [37:0] pra [3];
	logic signed [37:0] prb [3];

	assign damag = da[36] ? 36'(-da) : 36'(da);
	assign dbmag = db[36] ? 36'(-db) : 36'(db);

	for (genvar i = 0; i < 3; i++) begin : g_axis
		logic [31:0] uu;
		logic [30:0] umag;

		assign uu   = bk_d76.u[i];
		assign umag = uu[31] ? 31'(-uu) : uu[30:0];

		cir_rnd_mul #(.AMW(36), .BMW(31), .SH(30), .RW(38)) u_mul_a (
			.clk  (clk),
			.en   (en),
			.a_mag(damag),
			.b_mag(umag),
			.neg  (da[36] ^ uu[31]),
			.res  (pra[i])
		);

		cir_rnd_mul #(.AMW(36), .BMW(31), .SH(30), .RW(38)) u_mul_b (
			.clk  (clk),
			.en   (en),
			.a_mag(dbmag),
			.b_mag(umag),
			.neg  (db[36] ^ uu[31]),
			.res  (prb[i])
		);
	end

	// Stage 79: new velocities with saturation, or pass-through for a zero normal.
	logic signed [31:0] fva [3];
	logic signed [31:0] fvb [3];
	logic signed [31:0] nva [3];
	logic signed [31:0] nvb [3];

	assign fva[0] = bk_d78.c.item.vel_a_x;
	assign fva[1] = bk_d78.c.item.vel_a_y;
	assign fva[2] = bk_d78.c.item.vel_a_z;
	assign fvb[0] = bk_d78.c.item.vel_b_x;
	assign fvb[1] = bk_d78.c.item.vel_b_y;
	assign fvb[2] = bk_d78.c.item.vel_b_z;

	always_comb begin
		logic signed [38:0] sum_a;
		logic signed [38:0] sum_b;
		for (int i = 0; i < 3; i++) begin
			sum_a = 39'(fva[i]) + 39'(pra[i]);
			sum_b = 39'(fvb[i]) + 39'(prb[i]);
			if (bk_d78.c.deg) begin
				nva[i] = fva[i];
			end else if (sum_a > 39'sd2147483647) begin
				nva[i] = 32'sh7FFF_FFFF;
			end else if (sum_a < -39'sd2147483648) begin
				nva[i] = 32'sh8000_0000;
			end else begin
				nva[i] = 32'(sum_a);
			end
			if (bk_d78.c.deg) begin
				nvb[i] = fvb[i];
			end else if (sum_b > 39'sd2147483647) begin
				nvb[i] = 32'sh7FFF_FFFF;
			end else if (sum_b < -39'sd2147483648) begin
				nvb[i] = 32'sh8000_0000;
			end else begin
				nvb[i] = 32'(sum_b);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s79.new_vel_a_x       <= nva[0];
			res_s79.new_vel_a_y       <= nva[1];
			res_s79.new_vel_a_z       <= nva[2];
			res_s79.new_vel_b_x       <= nvb[0];
			res_s79.new_vel_b_y       <= nvb[1];
			res_s79.new_vel_b_z       <= nvb[2];
			res_s79.degenerate_normal <= bk_d78.c.deg;
		end
	end

	// Skid register: catches the last stage when the pipeline moves on
	// while the result is not taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_vld_q <= 1'b0;
		end else if (en) begin
			skid_vld_q <= vld_q[LAT-1] & ~result_ready;
		end else if (result_ready) begin
			skid_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			skid_q <= res_s79;
		end
	end

	assign result_valid = skid_vld_q | vld_q[LAT-1];
	assign result       = skid_vld_q ? skid_q : res_s79;

`ifndef SYNTHESIS
	// The skid register fills only from a valid, untaken last stage.
	a_skid_fill: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(vld_q[LAT-1] && !result_ready))
		else $error("skid register filled without a stalled result");

	// A held skid item keeps its value until taken.
	a_skid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q && !result_ready |=> skid_vld_q && $stable(skid_q))
		else $error("skid item changed while stalled");

	// The x component of the unit normal never exceeds one in magnitude.
	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[68] && !bk_s69.c.deg |->
		($signed(bk_s69.u[0]) <= 32'sh4000_0000) &&
		($signed(bk_s69.u[0]) >= -32'sh4000_0000))
		else $error("unit normal component out of range");
`endif

endmodule

`default_nettype wire

>>> design/cir_delay.sv
// Delay line with stall enable for the contact impulse resolver.
// Moves a payload word through DEPTH registers; no dependencies.
`default_nettype none

module cir_delay #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic [W-1:0] din,
	output logic      [W-1:0] dout
);

	logic [W-1:0] tap_q [DEPTH];

	// Shift one place whenever the pipeline advances.
	always_ff @(posedge clk) begin
		if (en) begin
			tap_q[0] <= din;
			for (int i = 1; i < DEPTH; i++) begin
				tap_q[i] <= tap_q[i-1];
			end
		end
	end

	assign dout = tap_q[DEPTH-1];

endmodule

`default_nettype wire

>>> design/cir_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Gives floor(sqrt(x)) after XW/2 stages; no dependencies.
`default_nettype none

module cir_isqrt #(
	parameter int XW = 64
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [XW-1:0]   x,
	output logic      [XW/2-1:0] root
);

	localparam int RW = XW / 2;

	logic [RW+1:0] rem_q  [RW];
	logic [RW-1:0] root_q [RW];
	logic [XW-1:0] x_q    [RW];

	for (genvar j = 0; j < RW; j++) begin : g_stage
		logic [RW+1:0] rem_in;
		logic [RW-1:0] root_in;
		logic [XW-1:0] x_in;
		logic [RW+2:0] cur;
		logic [RW+2:0] trial;
		logic [RW+2:0] diff;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_in  = '0;
			assign root_in = '0;
			assign x_in    = x;
		end else begin : g_next
			assign rem_in  = rem_q[j-1];
			assign root_in = root_q[j-1];
			assign x_in    = x_q[j-1];
		end

		// Bring down the next two radicand bits and try the next root bit.
		assign cur   = {rem_in[RW:0], x_in[XW-1 -: 2]};
		assign trial = {1'b0, root_in, 2'b01};
		assign diff  = cur - trial;
		assign take  = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j]  <= take ? diff[RW+1:0] : cur[RW+1:0];
				root_q[j] <= {root_in[RW-2:0], take};
				x_q[j]    <= {x_in[XW-3:0], 2'b00};
			end
		end
	end

	assign root = root_q[RW-1];

endmodule

`default_nettype wire

>>> design/cir_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Needs num >> QW below den; gives floor(num / den). No dependencies.
`default_nettype none

module cir_div #(
	parameter int NW = 62,
	parameter int DW = 32,
	parameter int QW = 31
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic      [QW-1:0] quo
);

	logic [DW-1:0] rem_q [QW];
	logic [QW-1:0] lo_q  [QW];
	logic [QW-1:0] quo_q [QW];
	logic [DW-1:0] den_q [QW];

	for (genvar j = 0; j < QW; j++) begin : g_stage
		logic [DW-1:0] rem_in;
		logic [QW-1:0] lo_in;
		logic [QW-1:0] quo_in;
		logic [DW-1:0] den_in;
		logic [DW:0]   cur;
		logic [DW:0]   diff;
		logic          take;

		if (j == 0) begin : g_first
			assign rem_in = DW'(num[NW-1:QW]);
			assign lo_in  = num[QW-1:0];
			assign quo_in = '0;
			assign den_in = den;
		end else begin : g_next
			assign rem_in = rem_q[j-1];
			assign lo_in  = lo_q[j-1];
			assign quo_in = quo_q[j-1];
			assign den_in = den_q[j-1];
		end

		// Shift in the next numerator bit and subtract where it fits.
		assign cur  = {rem_in, lo_in[QW-1]};
		assign diff = cur - {1'b0, den_in};
		assign take = (cur >= {1'b0, den_in});

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[j] <= take ? diff[DW-1:0] : cur[DW-1:0];
				lo_q[j]  <= {lo_in[QW-2:0], 1'b0};
				quo_q[j] <= {quo_in[QW-2:0], take};
				den_q[j] <= den_in;
			end
		end
	end

	assign quo = quo_q[QW-1];

endmodule

`default_nettype wire

>>> design/cir_rnd_mul.sv
// Two-stage sign-magnitude multiply with a rounding right shift.
// The wide operand is cut into two partial products; no dependencies.
`default_nettype none

module cir_rnd_mul #(
	parameter int AMW = 51,
	parameter int BMW = 31,
	parameter int SH  = 45,
	parameter int RW  = 37
) (
	input  wire logic                  clk,
	input  wire logic                  en,
	input  wire logic [AMW-1:0]        a_mag,
	input  wire logic [BMW-1:0]        b_mag,
	input  wire logic                  neg,
	output logic signed [RW-1:0]       res
);

	localparam int PW = AMW + BMW;
	localparam logic [PW:0] RND = (PW+1)'(1) << (SH - 1);

	logic [BMW+31:0]     plo_s1;
	logic [AMW-32+BMW-1:0] phi_s1;
	logic                neg_s1;
	logic signed [RW-1:0] res_s2;
	logic [PW:0]         full;
	logic [RW-2:0]       mag;

	// Partial products of the low word and the high part.
	always_ff @(posedge clk) begin
		if (en) begin
			plo_s1 <= (BMW+32)'(a_mag[31:0]) * (BMW+32)'(b_mag);
			phi_s1 <= (AMW-32+BMW)'(a_mag[AMW-1:32]) * (AMW-32+BMW)'(b_mag);
			neg_s1 <= neg;
		end
	end

	// Combine, round half away from zero on the magnitude, restore the sign.
	assign full = {1'b0, phi_s1, 32'h0} + (PW+1)'(plo_s1) + RND;
	assign mag  = full[SH +: RW-1];

	always_ff @(posedge clk) begin
		if (en) begin
			res_s2 <= neg_s1 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
		end
	end

	assign res = res_s2;

endmodule

`default_nettype wire
